@@ sv/bbal_pkg.sv @@
// Shared constants and types for the next-fit bitmap block allocator.
package bbal_pkg;

	localparam int MAX_BLOCKS = 4096;
	localparam int WORD_W     = 64;
	localparam int OFF_W      = $clog2(WORD_W);
	localparam int ROWS       = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
	localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int BLK_W      = 12;
	localparam int CNT_W      = 13;

	typedef enum logic [1:0] {
		OP_ALLOC_ANY   = 2'd0,
		OP_ALLOC_NAMED = 2'd1,
		OP_FREE        = 2'd2,
		OP_NOP         = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NO_FREE = 2'd1,
		ST_USED    = 2'd2,
		ST_RANGE   = 2'd3
	} status_t;

	typedef struct packed {
		logic              en;
		logic [ROW_W-1:0]  addr;
		logic [WORD_W-1:0] data;
	} map_wr_t;

endpackage

@@ sv/bbal_map_ram.sv @@
// Bitmap word memory with registered read and per-row valid bits cleared at reset.
module bbal_map_ram (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [bbal_pkg::ROW_W-1:0]   rd_addr,
	output logic [bbal_pkg::WORD_W-1:0]  rd_data,
	input  bbal_pkg::map_wr_t            wr
);

	logic [bbal_pkg::WORD_W-1:0] mem [bbal_pkg::ROWS];
	logic [bbal_pkg::ROWS-1:0]   vld_q;
	logic [bbal_pkg::WORD_W-1:0] rd_data_s1;
	logic                        rd_vld_s1;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
			rd_vld_s1  <= vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr.en) begin
			vld_q[wr.addr] <= 1'b1;
		end
	end

	// rows never written read as all free
	assign rd_data = rd_vld_s1 ? rd_data_s1 : '0;

endmodule

@@ sv/bbal_ffs.sv @@
// Lowest set bit finder over one bitmap word, binary halving tree.
module bbal_ffs (
	input  logic [bbal_pkg::WORD_W-1:0] word,
	output logic [bbal_pkg::OFF_W-1:0]  idx
);

	always_comb begin
		logic [bbal_pkg::WORD_W-1:0] v;
		logic [bbal_pkg::WORD_W-1:0] lowmask;
		v   = word;
		idx = '0;
		for (int lvl = bbal_pkg::OFF_W - 1; lvl >= 0; lvl--) begin
			lowmask = (bbal_pkg::WORD_W'(1) << (1 << lvl)) - bbal_pkg::WORD_W'(1);
			if ((v & lowmask) == '0) begin
				idx[lvl] = 1'b1;
				v        = v >> (1 << lvl);
			end
		end
	end

endmodule

@@ sv/block_bitmap_allocator_top.sv @@
// Top level: next-fit bitmap block allocator with word-serial search over the map memory.
//
//  channel | direction | handshake            | payload
//  in      | in        | in_valid / in_ready  | op, block_number
//  out     | out       | out_valid / out_ready| status, granted_block, used_count
//  cfg     | in        | cfg_wr_en            | cfg_wr_data (blocks_in_volume)
//
// Named allocate/free: read row, modify and write back, hand to output.
// Allocate any: k rows read, k = 1 to 65 (one 64-bit row per cycle), then hand to output.
// One request in flight; in_ready is high only between requests.
// Reset leaves the map all free at once (per-row valid bits); no sweep.
// A result held by out_ready low stalls only the finish of the next request.
module block_bitmap_allocator_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [bbal_pkg::CNT_W-1:0]    cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    op,
	input  logic [bbal_pkg::BLK_W-1:0]    block_number,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    status,
	output logic [bbal_pkg::BLK_W-1:0]    granted_block,
	output logic [bbal_pkg::CNT_W-1:0]    used_count
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_NAMED = 4'b0100,
		S_FIN   = 4'b1000
	} state_t;

	localparam int W  = bbal_pkg::WORD_W;
	localparam int OW = bbal_pkg::OFF_W;
	localparam int RW = bbal_pkg::ROW_W;
	localparam int BW = bbal_pkg::BLK_W;
	localparam int CW = bbal_pkg::CNT_W;

	state_t                state_q;
	logic [CW-1:0]         cfg_q;
	logic [CW-1:0]         hint_q;
	logic [CW-1:0]         used_q;
	bbal_pkg::op_t         op_q;
	logic [BW-1:0]         blk_q;
	logic [RW-1:0]         row_q;
	logic [RW-1:0]         start_row_q;
	logic [OW-1:0]         start_off_q;
	logic                  final_q;
	bbal_pkg::status_t     res_status_q;
	logic [BW-1:0]         res_granted_q;
	logic                  out_valid_q;
	bbal_pkg::status_t     out_status_q;
	logic [BW-1:0]         out_granted_q;
	logic [CW-1:0]         out_used_q;

	logic [CW-1:0]         n_c;
	logic [BW-1:0]         n_m1_c;
	logic [RW-1:0]         last_row_c;
	logic [OW-1:0]         tail_off_c;
	logic [BW-1:0]         start_c;
	logic                  rd_en;
	logic [RW-1:0]         rd_addr;
	logic [W-1:0]          rd_data;
	bbal_pkg::map_wr_t     map_wr;
	logic [W-1:0]          mask_c;
	logic [W-1:0]          free_c;
	logic [OW-1:0]         idx_c;
	logic                  found_c;
	logic [RW-1:0]         next_row_c;
	logic                  named_bit_c;
	logic [W-1:0]          named_m_c;
	logic                  accept;
	logic                  fin_go;

	bbal_map_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr      (map_wr)
	);

	bbal_ffs u_ffs (
		.word (free_c),
		.idx  (idx_c)
	);

	assign n_c        = (cfg_q > CW'(bbal_pkg::MAX_BLOCKS)) ? CW'(bbal_pkg::MAX_BLOCKS) : cfg_q;
	assign n_m1_c     = BW'(n_c - CW'(1));
	assign last_row_c = n_m1_c[BW-1:OW];
	assign tail_off_c = n_c[OW-1:0];
	assign start_c    = (hint_q >= n_c) ? '0 : hint_q[BW-1:0];

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign fin_go   = (state_q == S_FIN) && (!out_valid_q || out_ready);

	// search window within the current row
	always_comb begin
		mask_c = '1;
		if (row_q == last_row_c && tail_off_c != '0) begin
			mask_c = mask_c & ((W'(1) << tail_off_c) - W'(1));
		end
		if (row_q == start_row_q) begin
			if (final_q) begin
				mask_c = mask_c & ((W'(1) << start_off_q) - W'(1));
			end else begin
				mask_c = mask_c & ~((W'(1) << start_off_q) - W'(1));
			end
		end
	end

	assign free_c      = ~rd_data & mask_c;
	assign found_c     = |free_c;
	assign next_row_c  = (row_q == last_row_c) ? '0 : row_q + RW'(1);
	assign named_bit_c = rd_data[blk_q[OW-1:0]];
	assign named_m_c   = W'(1) << blk_q[OW-1:0];

	always_comb begin
		rd_en       = 1'b0;
		rd_addr     = row_q;
		map_wr.en   = 1'b0;
		map_wr.addr = row_q;
		map_wr.data = rd_data;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (op == bbal_pkg::OP_ALLOC_ANY) begin
						rd_en   = (n_c != '0);
						rd_addr = start_c[BW-1:OW];
					end else if (op inside {bbal_pkg::OP_ALLOC_NAMED, bbal_pkg::OP_FREE}) begin
						rd_en   = ({1'b0, block_number} < n_c);
						rd_addr = block_number[BW-1:OW];
					end
				end
			end
			S_SCAN: begin
				if (found_c) begin
					map_wr.en   = 1'b1;
					map_wr.data = rd_data | (W'(1) << idx_c);
				end else if (!(final_q || (next_row_c == start_row_q && start_off_q == '0))) begin
					rd_en   = 1'b1;
					rd_addr = next_row_c;
				end
			end
			S_NAMED: begin
				map_wr.addr = blk_q[BW-1:OW];
				if (op_q == bbal_pkg::OP_ALLOC_NAMED) begin
					map_wr.en   = !named_bit_c;
					map_wr.data = rd_data | named_m_c;
				end else begin
					map_wr.en   = named_bit_c;
					map_wr.data = rd_data & ~named_m_c;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cfg_q       <= CW'(4096);
			hint_q      <= '0;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cfg_q <= cfg_wr_data;
			end
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (op == bbal_pkg::OP_ALLOC_ANY) begin
							state_q <= (n_c == '0) ? S_FIN : S_SCAN;
						end else if (op inside {bbal_pkg::OP_ALLOC_NAMED,
								bbal_pkg::OP_FREE}) begin
							state_q <= ({1'b0, block_number} < n_c) ? S_NAMED : S_FIN;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_SCAN: begin
					if (found_c) begin
						hint_q  <= CW'({row_q, idx_c}) + CW'(1);
						used_q  <= used_q + CW'(1);
						state_q <= S_FIN;
					end else if (final_q || (next_row_c == start_row_q && start_off_q == '0)) begin
						state_q <= S_FIN;
					end
				end
				S_NAMED: begin
					if (op_q == bbal_pkg::OP_ALLOC_NAMED) begin
						if (!named_bit_c) begin
							used_q <= used_q + CW'(1);
						end
					end else if (named_bit_c) begin
						if (used_q != '0) begin
							used_q <= used_q - CW'(1);
						end
						if (hint_q > CW'(blk_q)) begin
							hint_q <= CW'(blk_q);
						end
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (fin_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request datapath, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q          <= bbal_pkg::op_t'(op);
					blk_q         <= block_number;
					row_q         <= start_c[BW-1:OW];
					start_row_q   <= start_c[BW-1:OW];
					start_off_q   <= start_c[OW-1:0];
					final_q       <= 1'b0;
					res_granted_q <= '0;
					if (op == bbal_pkg::OP_ALLOC_ANY && n_c == '0) begin
						res_status_q <= bbal_pkg::ST_NO_FREE;
					end else if (op inside {bbal_pkg::OP_ALLOC_NAMED, bbal_pkg::OP_FREE}
							&& {1'b0, block_number} >= n_c) begin
						res_status_q <= bbal_pkg::ST_RANGE;
					end else begin
						res_status_q <= bbal_pkg::ST_OK;
					end
				end
			end
			S_SCAN: begin
				if (found_c) begin
					res_granted_q <= {row_q, idx_c};
					res_status_q  <= bbal_pkg::ST_OK;
				end else if (final_q || (next_row_c == start_row_q && start_off_q == '0)) begin
					res_status_q <= bbal_pkg::ST_NO_FREE;
				end else begin
					row_q   <= next_row_c;
					final_q <= (next_row_c == start_row_q);
				end
			end
			S_NAMED: begin
				if (op_q == bbal_pkg::OP_ALLOC_NAMED && named_bit_c) begin
					res_status_q <= bbal_pkg::ST_USED;
				end
			end
			S_FIN: begin
				if (fin_go) begin
					out_status_q  <= res_status_q;
					out_granted_q <= res_granted_q;
					out_used_q    <= used_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign granted_block = out_granted_q;
	assign used_count    = out_used_q;

`ifndef SYNTHESIS
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(bbal_pkg::MAX_BLOCKS))
		else $error("used count above capacity");

	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && granted_block != '0 |-> status == bbal_pkg::ST_OK)
		else $error("granted block on a failed request");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(map_wr.en && rd_en))
		else $error("map read and write in the same cycle");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken while one is in flight");
`endif

endmodule
